>>> rtl/core/chip8_instruction_core_unit_macros.svh
// Assertion macros for the instruction core.
`ifndef CHIP8_INSTRUCTION_CORE_UNIT_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define C8_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define C8_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define C8_ASSERT_IMP(label, clk, rst_n, a, c)
`define C8_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/core/c8core_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_pkg
// Shared types and constants of the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package c8core_pkg;
	localparam int MemBytes   = 4096;
	localparam int StackDepth = 16;
	localparam logic [11:0] PcReset    = 12'h200;
	localparam logic [11:0] ScreenBase = 12'hF00;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0, OP_EXEC = 2'd1, OP_READ = 2'd2, OP_VREAD = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_INVALID = 3'd1, ST_KEY = 3'd2,
		ST_OVERFLOW = 3'd3, ST_UNDERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [11:0] address;
		logic [7:0]  write_data;
		logic [7:0]  random_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [11:0] program_counter;
		logic [2:0]  status;
	} out_item_t;

	// Memory port request from the sequencer to the memory module.
	typedef struct packed {
		logic        rd_en;
		logic        wr_en;
		logic [11:0] addr;
		logic [7:0]  wdata;
	} mem_req_t;
endpackage
`default_nettype wire

>>> rtl/core/c8core_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface c8core_stream_if #(parameter type payload_t = logic [7:0]);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/c8core_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_mem
// Main byte memory, one port, registered read data.
// ----------------------------------------------------------------------------
module c8core_mem #(
	parameter int MEM_BYTES = 4096
) (
	input  wire logic                  clk,
	input  wire c8core_pkg::mem_req_t  req,
	output logic [7:0]                 rdata
);
	import c8core_pkg::*;
	localparam int AW = $clog2(MEM_BYTES);
	logic [7:0] mem [MEM_BYTES];
	always_ff @(posedge clk) begin
		if (req.wr_en) mem[req.addr[AW-1:0]] <= req.wdata;
		if (req.rd_en) rdata <= mem[req.addr[AW-1:0]];
	end
endmodule
`default_nettype wire

>>> rtl/core/c8core_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_seq
// Sequencer: clearing pass, fetch, execute, screen clear, draw and block memory walks.
// ----------------------------------------------------------------------------
`include "chip8_instruction_core_unit_macros.svh"
module c8core_seq #(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire c8core_pkg::in_item_t in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output c8core_pkg::out_item_t     out_data,
	output c8core_pkg::mem_req_t      req,
	input  wire logic [7:0]           rdata
);
	import c8core_pkg::*;
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [11:0] {
		S_CLEAR = 12'b000000000001, S_IDLE  = 12'b000000000010,
		S_RDW   = 12'b000000000100, S_F1    = 12'b000000001000,
		S_F2    = 12'b000000010000, S_EXEC  = 12'b000000100000,
		S_SCLR  = 12'b000001000000, S_BLK   = 12'b000010000000,
		S_DRAWR = 12'b000100000000, S_DRAWP = 12'b001000000000,
		S_DRAWW = 12'b010000000000, S_DONE  = 12'b100000000000
	} state_t;

	state_t      state_q;
	in_item_t    item_q;
	logic [11:0] pc_q, i_q;
	logic [7:0]  v_q [16];
	logic [11:0] stk_q [STACK_DEPTH];
	logic [11:0] ret_q;
	logic [CW-1:0] sp_q;
	logic [7:0]  dt_q, st_q;
	logic [15:0] opc_q;
	logic [12:0] cnt_q;
	logic [7:0]  bits_q, cur_q;
	logic [3:0]  col_q;
	logic        hit_q;
	logic [11:0] pa_q;
	logic [7:0]  mask_q;
	out_item_t   out_q;
	logic        out_valid_q;

	logic [3:0] x, y, n;
	logic [7:0] kk, vx, vy;
	logic [11:0] nnn, next_pc, skip_pc;
	assign x = opc_q[11:8];
	assign y = opc_q[7:4];
	assign n = opc_q[3:0];
	assign kk = opc_q[7:0];
	assign nnn = opc_q[11:0];
	assign vx = v_q[x];
	assign vy = v_q[y];
	assign next_pc = pc_q + 12'd2;
	assign skip_pc = pc_q + 12'd4;

	// Decimal digits of Vx by reciprocal multiplication (exact for 8 bits).
	logic [15:0] div100_p, div10_p;
	logic [7:0]  bcd_h, bcd_t, bcd_o;
	assign div100_p = 16'(vx) * 16'd41;
	assign div10_p  = 16'(vx) * 16'd205;
	assign bcd_h = {4'd0, div100_p[15:12]};
	assign bcd_t = {3'd0, div10_p[15:11]} - bcd_h * 8'd10;
	assign bcd_o = vx - {3'd0, div10_p[15:11]} * 8'd10;

	// Pixel address for the current sprite row and column.
	logic [4:0] py;
	logic [5:0] px;
	assign py = 5'(vy + 8'(cnt_q[3:0]));
	assign px = 6'(vx + 8'(col_q));

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		req = '0;
		case (state_q)
			S_CLEAR: begin
				req.wr_en = 1'b1; req.addr = cnt_q[11:0]; req.wdata = '0;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					case (op_t'(in_data.op))
						OP_WRITE: begin
							req.wr_en = 1'b1; req.addr = in_data.address;
							req.wdata = in_data.write_data;
						end
						OP_READ: begin req.rd_en = 1'b1; req.addr = in_data.address; end
						OP_EXEC: begin req.rd_en = 1'b1; req.addr = pc_q; end
						default: ;
					endcase
				end
			end
			S_F1: begin req.rd_en = 1'b1; req.addr = pc_q + 12'd1; end
			S_SCLR: begin
				req.wr_en = 1'b1; req.addr = ScreenBase + 12'(cnt_q[7:0]);
			end
			S_BLK: begin
				req.addr = i_q + 12'(cnt_q[3:0]);
				if (kk == 8'h33) begin
					req.wr_en = 1'b1;
					case (cnt_q[1:0])
						2'd0: req.wdata = bcd_h;
						2'd1: req.wdata = bcd_t;
						default: req.wdata = bcd_o;
					endcase
				end else if (kk == 8'h55) begin
					req.wr_en = 1'b1; req.wdata = v_q[cnt_q[3:0]];
				end else req.rd_en = 1'b1;
			end
			S_DRAWR: begin
				req.rd_en = 1'b1;
				if (cnt_q[12]) req.addr = pa_q;
				else req.addr = i_q + 12'(cnt_q[3:0]);
			end
			S_DRAWW: begin
				req.wr_en = 1'b1; req.addr = pa_q; req.wdata = rdata ^ mask_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			pc_q <= PcReset;
			i_q <= '0;
			sp_q <= '0;
			dt_q <= '0;
			st_q <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 16; k++) v_q[k] <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 13'd1;
					if (cnt_q == 13'(MemBytes - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_data;
						case (op_t'(in_data.op))
							OP_WRITE: begin
								out_q <= '{8'd0, pc_q, ST_OK}; out_valid_q <= 1'b1;
							end
							OP_VREAD: begin
								out_q <= '{v_q[in_data.address[3:0]], pc_q, ST_OK};
								out_valid_q <= 1'b1;
							end
							OP_READ: state_q <= S_RDW;
							default: state_q <= S_F1;
						endcase
					end
				end
				S_RDW: begin
					out_q <= '{rdata, pc_q, ST_OK}; out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_F1: begin opc_q[15:8] <= rdata; state_q <= S_F2; end
				S_F2: begin
					opc_q[7:0] <= rdata;
					// Top of stack is read in S_F2 so the return in S_EXEC has it registered.
					ret_q <= stk_q[SW'(sp_q - 1'b1)];
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_DONE;
					out_q <= '{8'd0, next_pc, ST_OK};
					cnt_q <= '0;
					case (opc_q[15:12])
						4'h0: begin
							if (nnn == 12'h0E0) state_q <= S_SCLR;
							else if (nnn == 12'h0EE) begin
								if (sp_q == '0) out_q <= '{8'd0, pc_q, ST_UNDERFLOW};
								else begin
									sp_q <= sp_q - 1'b1;
									out_q.program_counter <= ret_q;
								end
							end else out_q <= '{8'd0, pc_q, ST_INVALID};
						end
						4'h1: out_q.program_counter <= nnn;
						4'h2: begin
							if (sp_q == CW'(STACK_DEPTH))
								out_q <= '{8'd0, pc_q, ST_OVERFLOW};
							else begin
								stk_q[SW'(sp_q)] <= next_pc;
								sp_q <= sp_q + 1'b1;
								out_q.program_counter <= nnn;
							end
						end
						4'h3: if (vx == kk) out_q.program_counter <= skip_pc;
						4'h4: if (vx != kk) out_q.program_counter <= skip_pc;
						4'h5: if (vx == vy) out_q.program_counter <= skip_pc;
						4'h6: v_q[x] <= kk;
						4'h7: v_q[x] <= vx + kk;
						4'h8: begin
							case (n)
								4'h0: v_q[x] <= vy;
								4'h1: v_q[x] <= vx | vy;
								4'h2: v_q[x] <= vx & vy;
								4'h3: v_q[x] <= vx ^ vy;
								4'h4: begin
									v_q[15] <= {7'd0, 9'(vx) + 9'(vy) > 9'hFF};
									v_q[x] <= vx + vy;
								end
								4'h5: begin v_q[15] <= {7'd0, vx > vy}; v_q[x] <= vx - vy; end
								4'h6: begin v_q[15] <= {7'd0, vx[0]}; v_q[x] <= vx >> 1; end
								4'h7: begin v_q[15] <= {7'd0, vy > vx}; v_q[x] <= vy - vx; end
								4'hE: begin v_q[15] <= {7'd0, vx[7]}; v_q[x] <= vx << 1; end
								default: out_q <= '{8'd0, pc_q, ST_INVALID};
							endcase
						end
						4'h9: if (vx != vy) out_q.program_counter <= skip_pc;
						4'hA: i_q <= nnn;
						4'hB: out_q.program_counter <= nnn + 12'(v_q[0]);
						4'hC: v_q[x] <= item_q.random_byte & kk;
						4'hD: begin
							hit_q <= 1'b0;
							if (n == 4'd0) v_q[15] <= '0;
							else state_q <= S_DRAWR;
						end
						4'hE: begin
							if (kk == 8'h9E || kk == 8'hA1) out_q.status <= ST_KEY;
							else out_q <= '{8'd0, pc_q, ST_INVALID};
						end
						default: begin
							case (kk)
								8'h07: v_q[x] <= dt_q;
								8'h0A: out_q.status <= ST_KEY;
								8'h15: dt_q <= vx;
								8'h18: st_q <= vx;
								8'h1E: i_q <= i_q + 12'(vx);
								8'h29: i_q <= 12'(vx) * 12'd5;
								8'h33, 8'h55, 8'h65: state_q <= S_BLK;
								default: out_q <= '{8'd0, pc_q, ST_INVALID};
							endcase
						end
					endcase
				end
				S_SCLR: begin
					cnt_q <= cnt_q + 13'd1;
					if (cnt_q[7:0] == 8'hFF) state_q <= S_DONE;
				end
				S_BLK: begin
					// Read data is registered in the memory; cnt_q[12] marks that rdata holds
					// the entry one below the current index.
					if (kk == 8'h65) begin
						if (cnt_q[12]) v_q[cnt_q[3:0] - 4'd1] <= rdata;
						if (cnt_q[12] && (cnt_q[3:0] - 4'd1) == x) state_q <= S_DONE;
						else cnt_q <= {1'b1, cnt_q[11:0] + 12'd1};
					end else if (kk == 8'h33 ? cnt_q[1:0] == 2'd2 : cnt_q[3:0] == x)
						state_q <= S_DONE;
					else cnt_q <= cnt_q + 13'd1;
				end
				S_DRAWR: begin
					if (cnt_q[12]) state_q <= S_DRAWW;
					else begin state_q <= S_DRAWP; col_q <= '0; end
				end
				S_DRAWP: begin
					if (col_q == 4'd0) bits_q <= rdata;
					if (col_q == 4'd8) begin
						col_q <= '0;
						if (cnt_q[3:0] + 4'd1 == n) begin
							v_q[15] <= {7'd0, hit_q}; state_q <= S_DONE;
						end else begin
							cnt_q <= cnt_q + 13'd1; state_q <= S_DRAWR;
						end
					end else if ((col_q == 4'd0 ? rdata[7] : bits_q[3'd7 - col_q[2:0]])) begin
						pa_q <= ScreenBase + {4'd0, py, px[5:3]};
						mask_q <= 8'h80 >> px[2:0];
						cnt_q[12] <= 1'b1;
						state_q <= S_DRAWR;
					end else col_q <= col_q + 4'd1;
				end
				S_DRAWW: begin
					if ((rdata & mask_q) != 8'd0) hit_q <= 1'b1;
					cnt_q[12] <= 1'b0;
					col_q <= col_q + 4'd1;
					state_q <= S_DRAWP;
				end
				S_DONE: begin
					pc_q <= out_q.program_counter;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`C8_ASSERT_IMP(a_stack_bound, clk, arst_n, 1'b1, sp_q <= CW'(STACK_DEPTH))
	`C8_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !in_ready)
	`C8_ASSERT_NXT(a_done_out, clk, arst_n, state_q == S_DONE, out_valid_q)
	`C8_ASSERT_IMP(a_one_access, clk, arst_n, 1'b1, !(req.rd_en && req.wr_en))
endmodule
`default_nettype wire

>>> rtl/core/chip8_instruction_core_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_core_unit
// CHIP-8 core: byte memory access and single-instruction execution.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_ch     sink       op, address, write_data, random_byte
// out_ch    source     read_data, program_counter, status
//
// After reset a clearing pass zeroes the 4096-byte memory, one byte a cycle;
// no transfer is accepted meanwhile.
// Writes and register reads answer from idle; memory reads pass a wait state.
// An instruction is fetched through the single memory port, then executed;
// a clear, a block move and a draw add walks over memory.
// One item is in flight; the next is accepted once the result is taken.
`include "chip8_instruction_core_unit_macros.svh"
module chip8_instruction_core_unit #(
	parameter int MEM_BYTES   = c8core_pkg::MemBytes,
	parameter int STACK_DEPTH = c8core_pkg::StackDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	c8core_stream_if.sink   in_ch,
	c8core_stream_if.source out_ch
);
	import c8core_pkg::*;
	mem_req_t   req;
	logic [7:0] rdata;

	// The memory port is owned by the sequencer; each state issues at most one access.
	c8core_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (.clk(clk), .req(req), .rdata(rdata));

	c8core_seq #(.STACK_DEPTH(STACK_DEPTH)) u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.req(req), .rdata(rdata)
	);

	`C8_ASSERT_NXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
	`C8_ASSERT_IMP(a_busy_out, clk, arst_n, out_ch.valid, !in_ch.ready)
	`C8_ASSERT_NXT(a_in_then_idle, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
endmodule
`default_nettype wire

>>> tb/sv/chip8_instruction_core_unit_checker.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_core_unit_checker
// Watches both channels, keeps a shadow copy of the core's state, works out
// the expected result of every accepted item and compares it with the core.
// ----------------------------------------------------------------------------
module chip8_instruction_core_unit_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input c8core_pkg::in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input c8core_pkg::out_item_t out_data,
	output int errors,
	output int pending,
	output int status_seen [5]
);
	import c8core_pkg::*;

	logic [7:0]  mem [MemBytes];
	logic [7:0]  vreg [16];
	logic [11:0] ireg;
	logic [11:0] pc;
	logic [11:0] ret_stack [StackDepth];
	int          depth;
	logic [7:0]  delay_b;
	logic [7:0]  sound_b;
	out_item_t   expected_q [$];

	assign pending = expected_q.size();

	function automatic logic [7:0] mrd(input logic [11:0] a);
		return mem[a];
	endfunction

	// Executes the instruction at pc; returns the status and updates state.
	function automatic status_t run_insn(input logic [7:0] rnd);
		logic [15:0] opc;
		logic [3:0]  x, y, n;
		logic [7:0]  kk, a, b, bits, mask, rows;
		logic [11:0] nnn, nxt, skp, adr;
		logic [8:0]  sum;
		logic        hit;
		logic [5:0]  px;
		logic [4:0]  py;
		opc = {mrd(pc), mrd(pc + 12'd1)};
		x = opc[11:8]; y = opc[7:4]; n = opc[3:0]; kk = opc[7:0]; nnn = opc[11:0];
		nxt = pc + 12'd2;
		skp = pc + 12'd4;
		a = vreg[x];
		b = vreg[y];
		case (opc[15:12])
			4'h0: begin
				if (nnn == 12'h0E0) begin
					for (int k = 0; k < 256; k++) mem[ScreenBase + k] = 8'h00;
				end else if (nnn == 12'h0EE) begin
					if (depth == 0) return ST_UNDERFLOW;
					depth--;
					nxt = ret_stack[depth];
				end else begin
					return ST_INVALID;
				end
			end
			4'h1: nxt = nnn;
			4'h2: begin
				if (depth >= StackDepth) return ST_OVERFLOW;
				ret_stack[depth] = nxt;
				depth++;
				nxt = nnn;
			end
			4'h3: if (a == kk) nxt = skp;
			4'h4: if (a != kk) nxt = skp;
			4'h5: if (a == b) nxt = skp;
			4'h6: vreg[x] = kk;
			4'h7: vreg[x] = a + kk;
			4'h8: begin
				case (n)
					4'h0: vreg[x] = b;
					4'h1: vreg[x] = a | b;
					4'h2: vreg[x] = a & b;
					4'h3: vreg[x] = a ^ b;
					4'h4: begin
						sum = a + b;
						vreg[15] = {7'd0, sum[8]};
						vreg[x] = sum[7:0];
					end
					4'h5: begin vreg[15] = {7'd0, a > b}; vreg[x] = a - b; end
					4'h6: begin vreg[15] = {7'd0, a[0]}; vreg[x] = a >> 1; end
					4'h7: begin vreg[15] = {7'd0, b > a}; vreg[x] = b - a; end
					4'hE: begin vreg[15] = {7'd0, a[7]}; vreg[x] = a << 1; end
					default: return ST_INVALID;
				endcase
			end
			4'h9: if (a != b) nxt = skp;
			4'hA: ireg = nnn;
			4'hB: nxt = nnn + {4'd0, vreg[0]};
			4'hC: vreg[x] = rnd & kk;
			4'hD: begin
				hit = 1'b0;
				rows = {4'd0, n};
				for (int r = 0; r < rows; r++) begin
					bits = mrd(ireg + r[11:0]);
					py = b[4:0] + r[4:0];
					for (int c = 0; c < 8; c++) begin
						if (bits[7 - c]) begin
							px = a[5:0] + c[5:0];
							adr = ScreenBase + {py, px[5:3]};
							mask = 8'h80 >> px[2:0];
							if (mem[adr] & mask) hit = 1'b1;
							mem[adr] = mem[adr] ^ mask;
						end
					end
				end
				vreg[15] = {7'd0, hit};
			end
			4'hE: begin
				if (kk == 8'h9E || kk == 8'hA1) begin
					pc = nxt;
					return ST_KEY;
				end
				return ST_INVALID;
			end
			default: begin
				case (kk)
					8'h07: vreg[x] = delay_b;
					8'h0A: begin pc = nxt; return ST_KEY; end
					8'h15: delay_b = a;
					8'h18: sound_b = a;
					8'h1E: ireg = ireg + {4'd0, a};
					8'h29: ireg = a * 12'd5;
					8'h33: begin
						mem[ireg] = a / 100;
						mem[ireg + 12'd1] = (a / 10) % 10;
						mem[ireg + 12'd2] = a % 10;
					end
					8'h55: for (int k = 0; k <= x; k++) mem[ireg + k[11:0]] = vreg[k];
					8'h65: for (int k = 0; k <= x; k++) vreg[k] = mem[ireg + k[11:0]];
					default: return ST_INVALID;
				endcase
			end
		endcase
		pc = nxt;
		return ST_OK;
	endfunction

	function automatic out_item_t predict_result(input in_item_t it);
		out_item_t res;
		res = '0;
		case (op_t'(it.op))
			OP_WRITE: mem[it.address] = it.write_data;
			OP_EXEC:  res.status = run_insn(it.random_byte);
			OP_READ:  res.read_data = mem[it.address];
			default:  res.read_data = vreg[it.address[3:0]];
		endcase
		res.program_counter = pc;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			foreach (mem[k]) mem[k] = 8'h00;
			foreach (vreg[k]) vreg[k] = 8'h00;
			foreach (ret_stack[k]) ret_stack[k] = 12'h000;
			foreach (status_seen[k]) status_seen[k] = 0;
			ireg = 12'h000;
			pc = PcReset;
			depth = 0;
			delay_b = 8'h00;
			sound_b = 8'h00;
			errors = 0;
			expected_q.delete();
		end else begin
			// Results are checked before new items so a same-edge accept cannot race.
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $time, out_data);
				end else begin
					want = expected_q.pop_front();
					if (want.read_data !== out_data.read_data) begin
						errors++;
						$display("%0t: read_data exp %h got %h", $time,
							want.read_data, out_data.read_data);
					end
					if (want.program_counter !== out_data.program_counter) begin
						errors++;
						$display("%0t: program_counter exp %h got %h", $time,
							want.program_counter, out_data.program_counter);
					end
					if (want.status !== out_data.status) begin
						errors++;
						$display("%0t: status exp %0d got %0d", $time,
							want.status, out_data.status);
					end
				end
			end
			if (in_valid && in_ready) begin
				want = predict_result(in_data);
				if (want.status <= 3'd4) status_seen[want.status]++;
				expected_q.push_back(want);
			end
		end
	end
endmodule
`default_nettype wire

>>> tb/sv/chip8_instruction_core_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_core_unit_tb
// Loads small programs into the core and runs them instruction by instruction
// under changing flow-control pressure; a separate checker predicts results.
// ----------------------------------------------------------------------------
module chip8_instruction_core_unit_tb;
	import c8core_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	c8core_stream_if #(.payload_t(in_item_t))  in_ch ();
	c8core_stream_if #(.payload_t(out_item_t)) out_ch ();

	int errors;
	int pending;
	int status_seen [5];
	int cycles = 0;
	// Chance in percent that the sender idles or the receiver stalls.
	int send_idle = 0;
	int recv_stall = 0;
	// Count of items handed to the core. The stack depth is mirrored by the
	// stimulus in stack_fill; returns are not filtered, and returns with an
	// empty stack are still exercised; they only flag underflow.
	int items_sent = 0;

	// Worst case: clearing pass, then up to about 2550 items, each with its work
	// plus stall waiting. Taken generously.
	localparam int CycleLimit = 5_000_000;

	chip8_instruction_core_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	chip8_instruction_core_unit_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.errors(errors),
		.pending(pending),
		.status_seen(status_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// The receiver side stalls at random according to the current phase.
	always @(posedge clk) begin
		if (arst_n) out_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	// Watchdog for a hung core.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Drives one item and holds it until the transfer happens. A random idle
	// gap comes first; valid stays high across back-to-back items.
	task automatic send_item(input op_t op, input logic [11:0] adr, input logic [7:0] wd,
			input logic [7:0] rnd);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{op: op, address: adr, write_data: wd, random_byte: rnd};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_byte(input logic [11:0] adr, input logic [7:0] val);
		send_item(OP_WRITE, adr, val, 8'h00);
	endtask

	// Executes the instruction at the current pc; address and data are noise.
	task automatic exec_insn(input logic [7:0] rnd);
		send_item(OP_EXEC, 12'($urandom_range(4095)), 8'($urandom_range(255)), rnd);
	endtask

	// Core pc is tracked by sampling results: we keep our own copy.
	logic [11:0] cur_pc = PcReset;
	int          stack_fill = 0;

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) cur_pc <= out_ch.data.program_counter;
	end

	// Waits for the last result so that cur_pc is current.
	task automatic drain;
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Writes an instruction at the current pc and executes it.
	task automatic run_opcode(input logic [15:0] opc, input logic [7:0] rnd);
		logic [11:0] p;
		drain();
		p = cur_pc;
		write_byte(p, opc[15:8]);
		write_byte(p + 12'd1, opc[7:0]);
		exec_insn(rnd);
	endtask

	function automatic logic [15:0] random_opcode();
		logic [15:0] o;
		int sel;
		o = 16'($urandom_range(16'hFFFF));
		sel = $urandom_range(99);
		if (sel < 15) o = {4'h8, o[11:4], 4'($urandom_range(7))};
		else if (sel < 20) o = {4'h8, o[11:4], 4'hE};
		else if (sel < 30) begin
			case ($urandom_range(8))
				0: o[7:0] = 8'h07;
				1: o[7:0] = 8'h15;
				2: o[7:0] = 8'h18;
				3: o[7:0] = 8'h1E;
				4: o[7:0] = 8'h29;
				5: o[7:0] = 8'h33;
				6: o[7:0] = 8'h55;
				7: o[7:0] = 8'h65;
				default: o[7:0] = 8'h0A;
			endcase
			o[15:12] = 4'hF;
		end else if (sel < 34) o = {4'hE, o[11:8], ($urandom_range(1) ? 8'h9E : 8'hA1)};
		else if (sel < 37) o = 16'h00E0;
		else if (sel < 42) o = 16'h00EE;
		else if (sel < 48) o = {4'h2, o[11:0]};
		else if (sel < 55) o = {4'hD, o[11:4], 4'($urandom_range(4))};
		else if (sel < 60) o = {4'hA, o[11:0]};
		return o;
	endfunction

	// Tracks the stack depth the stimulus expects; the opcode is passed on unchanged.
	function automatic logic [15:0] legal_opcode(input logic [15:0] o);
		if (o == 16'h00EE) begin
			if (stack_fill > 0) stack_fill--;
		end else if (o[15:12] == 4'h2) begin
			if (stack_fill < StackDepth) stack_fill++;
		end
		return o;
	endfunction

	task automatic run_phase(input int idle, input int stall, input int count);
		drain();
		send_idle = idle;
		recv_stall = stall;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(9))
				0: send_item(OP_WRITE, 12'($urandom_range(4095)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
				1: send_item(OP_READ, 12'($urandom_range(4095)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
				2: send_item(OP_VREAD, 12'($urandom_range(4095)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
				3: send_item(OP_EXEC, 12'($urandom_range(4095)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
				default: run_opcode(legal_opcode(random_opcode()), 8'($urandom_range(255)));
			endcase
		end
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		// Directed part: extremes, every operation and the special cases.
		write_byte(12'hFFF, 8'hFF);
		send_item(OP_READ, 12'hFFF, 8'h00, 8'h00);
		send_item(OP_READ, 12'h000, 8'h00, 8'h00);
		send_item(OP_VREAD, 12'hFFF, 8'h00, 8'h00);
		stack_fill = 0;
		run_opcode(16'h00EE, 8'h00);
		run_opcode(16'h6FFF, 8'h00);
		run_opcode(16'h60FF, 8'h00);
		run_opcode(16'h8F04, 8'h00);
		run_opcode(16'h8F05, 8'h00);
		run_opcode(16'h8F0E, 8'h00);
		run_opcode(16'hC3FF, 8'hA5);
		run_opcode(16'hA0FE, 8'h00);
		run_opcode(16'hD3F4, 8'h00);
		run_opcode(16'hD3F4, 8'h00);
		run_opcode(16'hD000, 8'h00);
		run_opcode(16'h00E0, 8'h00);
		run_opcode(16'h8128, 8'h00);
		run_opcode(16'h0123, 8'h00);
		run_opcode(16'hE1A1, 8'h00);
		run_opcode(16'hF10A, 8'h00);
		run_opcode(16'hF0FF, 8'h00);
		run_opcode(16'hFF55, 8'h00);
		run_opcode(16'hFF65, 8'h00);
		for (int k = 0; k < StackDepth + 1; k++) run_opcode(legal_opcode(16'h2FFE), 8'h00);
		run_opcode(16'hB0FF, 8'h00);
		// Random part in phases of flow-control pressure.
		run_phase(0, 0, 150);
		run_phase(68, 0, 150);
		run_phase(0, 68, 150);
		run_phase(24, 24, 150);
		run_phase(0, 0, 150);
		run_phase(68, 68, 60);
		drain();
		repeat (400) @(posedge clk);
		$display("Ran %0d items: %0d ok, %0d invalid, %0d key, %0d overflow, %0d underflow",
			items_sent, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4]);
		if (errors == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/c8core_pkg.sv
rtl/core/c8core_stream_if.sv
rtl/core/c8core_mem.sv
rtl/core/c8core_seq.sv
rtl/core/chip8_instruction_core_unit.sv
tb/sv/chip8_instruction_core_unit_checker.sv
tb/sv/chip8_instruction_core_unit_tb.sv
